### src/jvv_pkg.sv
// Shared types, constants and character tables for the JSON value validator.
`default_nettype none
package jvv_pkg;

    localparam int MAX_NESTING = 32;
    localparam int LVL_W       = $clog2(MAX_NESTING + 1);
    localparam int IDX_W       = $clog2(MAX_NESTING);

    localparam int MAX_LENGTH  = 65536;
    localparam int CNT_W       = $clog2(MAX_LENGTH + 1);
    localparam int POS_W       = 16;
    localparam int LEN_W       = 17;

    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = 40;

    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

    localparam int LP_W        = 4;
    localparam int LIT_COUNT   = 13;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_SYNTAX = 2'd1;
    localparam logic [1:0] STATUS_DEPTH  = 2'd2;
    localparam logic [1:0] STATUS_LENGTH = 2'd3;

    localparam logic [LP_W-1:0] LP_TRUE  = LP_W'(1);
    localparam logic [LP_W-1:0] LP_FALSE = LP_W'(5);
    localparam logic [LP_W-1:0] LP_NULL  = LP_W'(10);

    typedef enum logic [3:0] {
        ST_VALUE, ST_OPEN, ST_KEY, ST_KSTR, ST_KESC, ST_COLON,
        ST_AFTER, ST_TRAIL, ST_STR, ST_ESC, ST_NUM, ST_LIT
    } scan_state_t;

    typedef enum logic [3:0] {
        CL_WS, CL_NUM, CL_QUOTE, CL_BSLASH, CL_LBRACE, CL_LBRACK, CL_RBRACE,
        CL_RBRACK, CL_COMMA, CL_COLON, CL_T, CL_F, CL_N, CL_OTHER
    } char_class_t;

    typedef struct packed {
        logic [IN_DATA_W-1:0] data;
        char_class_t          cls;
        logic                 last;
        logic                 too_long;
        logic [POS_W-1:0]     offset;
    } beat_t;

    typedef struct packed {
        logic [LEN_W-1:0] value_length;
        logic [POS_W-1:0] value_start;
        logic [1:0]       status;
    } result_t;

    // characters of "true", "false", "null" back to back
    function automatic logic [7:0] lit_char(input logic [LP_W-1:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h74;
            4'd1:    c = 8'h72;
            4'd2:    c = 8'h75;
            4'd3:    c = 8'h65;
            4'd4:    c = 8'h66;
            4'd5:    c = 8'h61;
            4'd6:    c = 8'h6C;
            4'd7:    c = 8'h73;
            4'd8:    c = 8'h65;
            4'd9:    c = 8'h6E;
            4'd10:   c = 8'h75;
            4'd11:   c = 8'h6C;
            4'd12:   c = 8'h6C;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // position of the final character of each literal
    function automatic logic lit_final(input logic [LP_W-1:0] idx);
        return (idx == LP_W'(3)) || (idx == LP_W'(8)) || (idx == LP_W'(12));
    endfunction

endpackage
`default_nettype wire

### src/jvv_front.sv
// Front end: input beat acceptance, character classification and byte offset.
`default_nettype none
module jvv_front (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [jvv_pkg::IN_DATA_W-1:0]  s_tdata,
    input  wire logic                           s_tlast,
    input  wire logic                           fifo_full,
    output logic                                push,
    output jvv_pkg::beat_t                      beat
);

    logic [jvv_pkg::CNT_W-1:0] off_cnt_reg;
    logic [jvv_pkg::CNT_W-1:0] off_cnt_next;
    logic                      too_long;
    jvv_pkg::char_class_t      cls;

    assign s_tready = !fifo_full;
    assign push     = s_tvalid && s_tready;
    assign too_long = (off_cnt_reg == jvv_pkg::CNT_W'(jvv_pkg::MAX_LENGTH));

    always_comb begin
        unique case (s_tdata) inside
            8'h20, 8'h09, 8'h0D, 8'h0A:                 cls = jvv_pkg::CL_WS;
            [8'h30:8'h39], 8'h2E, 8'h2B, 8'h2D,
            [8'h61:8'h65], [8'h41:8'h46], 8'h78, 8'h58: cls = jvv_pkg::CL_NUM;
            8'h66:                                      cls = jvv_pkg::CL_F;
            8'h74:                                      cls = jvv_pkg::CL_T;
            8'h6E:                                      cls = jvv_pkg::CL_N;
            8'h22:                                      cls = jvv_pkg::CL_QUOTE;
            8'h5C:                                      cls = jvv_pkg::CL_BSLASH;
            8'h7B:                                      cls = jvv_pkg::CL_LBRACE;
            8'h5B:                                      cls = jvv_pkg::CL_LBRACK;
            8'h7D:                                      cls = jvv_pkg::CL_RBRACE;
            8'h5D:                                      cls = jvv_pkg::CL_RBRACK;
            8'h2C:                                      cls = jvv_pkg::CL_COMMA;
            8'h3A:                                      cls = jvv_pkg::CL_COLON;
            default:                                    cls = jvv_pkg::CL_OTHER;
        endcase
    end

    always_comb begin
        beat.data     = s_tdata;
        beat.cls      = cls;
        beat.last     = s_tlast;
        beat.too_long = too_long;
        beat.offset   = off_cnt_reg[jvv_pkg::POS_W-1:0];
    end

    always_comb begin
        off_cnt_next = off_cnt_reg;
        if (push) begin
            if (s_tlast) begin
                off_cnt_next = '0;
            end else if (!too_long) begin
                off_cnt_next = off_cnt_reg + jvv_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_cnt_reg <= '0;
        end else begin
            off_cnt_reg <= off_cnt_next;
        end
    end

endmodule
`default_nettype wire

### src/jvv_fifo.sv
// Short queue of classified beats between front end and scanner.
`default_nettype none
module jvv_fifo (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          push,
    input  wire jvv_pkg::beat_t                wr_beat,
    input  wire logic                          pop,
    output jvv_pkg::beat_t                     rd_beat,
    output logic                               full,
    output logic                               empty,
    output logic [jvv_pkg::FIFO_AW:0]          fill
);

    jvv_pkg::beat_t                 mem [jvv_pkg::FIFO_DEPTH];
    logic [jvv_pkg::FIFO_AW-1:0]    wr_ptr_reg;
    logic [jvv_pkg::FIFO_AW-1:0]    rd_ptr_reg;
    logic [jvv_pkg::FIFO_AW:0]      fill_reg;
    logic [jvv_pkg::FIFO_AW:0]      fill_next;

    assign full    = (fill_reg == (jvv_pkg::FIFO_AW + 1)'(jvv_pkg::FIFO_DEPTH));
    assign empty   = (fill_reg == '0);
    assign fill    = fill_reg;
    assign rd_beat = mem[rd_ptr_reg];

    always_comb begin
        fill_next = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + (jvv_pkg::FIFO_AW + 1)'(1);
        end else if (pop && !push) begin
            fill_next = fill_reg - (jvv_pkg::FIFO_AW + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_beat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + jvv_pkg::FIFO_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + jvv_pkg::FIFO_AW'(1);
            end
            fill_reg <= fill_next;
        end
    end

endmodule
`default_nettype wire

### src/jvv_back.sv
// Scanner: syntax state machine, nesting stack, marks and result register.
`default_nettype none
module jvv_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire jvv_pkg::beat_t    head,
    input  wire logic              fifo_empty,
    output logic                   pop,
    input  wire logic              m_tready,
    output logic                   m_tvalid,
    output jvv_pkg::result_t       result
);

    jvv_pkg::scan_state_t          state_reg, state_next, eff_state;
    logic [jvv_pkg::LVL_W-1:0]     level_reg, level_next, lvl_dec;
    logic [jvv_pkg::LP_W-1:0]      lp_reg, lp_next, lp_load_val;
    logic [jvv_pkg::POS_W-1:0]     start_reg, start_next;
    logic [jvv_pkg::CNT_W-1:0]     end_reg, end_next, end_final, off_inc;
    logic [1:0]                    err_reg, err_next, status;
    logic                          stack_reg [jvv_pkg::MAX_NESTING];

    logic m_valid_reg;
    jvv_pkg::result_t res_reg, res_next;

    logic is_ws, is_num, top_obj, closer_hit, scan_en;
    logic do_push, push_obj, do_pop, set_start, end_at_off, end_at_inc;
    logic lp_load, lp_inc;

    assign is_ws      = (head.cls == jvv_pkg::CL_WS);
    assign is_num     = (head.cls == jvv_pkg::CL_NUM) || (head.cls == jvv_pkg::CL_F);
    assign lvl_dec    = level_reg - jvv_pkg::LVL_W'(1);
    assign top_obj    = (level_reg != '0) && stack_reg[lvl_dec[jvv_pkg::IDX_W-1:0]];
    assign closer_hit = top_obj ? (head.cls == jvv_pkg::CL_RBRACE)
                                : (head.cls == jvv_pkg::CL_RBRACK);
    assign off_inc    = jvv_pkg::CNT_W'(head.offset) + jvv_pkg::CNT_W'(1);

    assign pop = !fifo_empty && (!head.last || !m_valid_reg || m_tready);

    // next state, error and control decisions
    always_comb begin
        state_next  = state_reg;
        err_next    = err_reg;
        eff_state   = state_reg;
        scan_en     = 1'b0;
        do_push     = 1'b0;
        push_obj    = 1'b0;
        do_pop      = 1'b0;
        set_start   = 1'b0;
        end_at_off  = 1'b0;
        end_at_inc  = 1'b0;
        lp_load     = 1'b0;
        lp_load_val = '0;
        lp_inc      = 1'b0;

        if (head.too_long) begin
            if (err_reg == jvv_pkg::STATUS_OK) begin
                err_next = jvv_pkg::STATUS_LENGTH;
            end
        end else if (err_reg == jvv_pkg::STATUS_OK) begin
            scan_en = 1'b1;
            // byte that ends an open bracket or a number is looked at again
            if (state_reg == jvv_pkg::ST_OPEN && !is_ws) begin
                if (closer_hit) begin
                    scan_en    = 1'b0;
                    do_pop     = 1'b1;
                    end_at_inc = (level_reg == jvv_pkg::LVL_W'(1));
                    state_next = end_at_inc ? jvv_pkg::ST_TRAIL : jvv_pkg::ST_AFTER;
                end else begin
                    eff_state = top_obj ? jvv_pkg::ST_KEY : jvv_pkg::ST_VALUE;
                end
            end else if (state_reg == jvv_pkg::ST_NUM && !is_num) begin
                end_at_off = (level_reg == '0);
                eff_state  = end_at_off ? jvv_pkg::ST_TRAIL : jvv_pkg::ST_AFTER;
            end

            if (scan_en) begin
                state_next = eff_state;
                unique case (eff_state)
                    jvv_pkg::ST_VALUE: begin
                        if (!is_ws) begin
                            set_start = (level_reg == '0);
                            unique case (head.cls)
                                jvv_pkg::CL_LBRACE, jvv_pkg::CL_LBRACK: begin
                                    if (level_reg ==
                                        jvv_pkg::LVL_W'(jvv_pkg::MAX_NESTING)) begin
                                        err_next = jvv_pkg::STATUS_DEPTH;
                                    end else begin
                                        do_push    = 1'b1;
                                        push_obj   = (head.cls == jvv_pkg::CL_LBRACE);
                                        state_next = jvv_pkg::ST_OPEN;
                                    end
                                end
                                jvv_pkg::CL_QUOTE: state_next = jvv_pkg::ST_STR;
                                jvv_pkg::CL_T: begin
                                    lp_load     = 1'b1;
                                    lp_load_val = jvv_pkg::LP_TRUE;
                                    state_next  = jvv_pkg::ST_LIT;
                                end
                                jvv_pkg::CL_F: begin
                                    lp_load     = 1'b1;
                                    lp_load_val = jvv_pkg::LP_FALSE;
                                    state_next  = jvv_pkg::ST_LIT;
                                end
                                jvv_pkg::CL_N: begin
                                    lp_load     = 1'b1;
                                    lp_load_val = jvv_pkg::LP_NULL;
                                    state_next  = jvv_pkg::ST_LIT;
                                end
                                jvv_pkg::CL_NUM: state_next = jvv_pkg::ST_NUM;
                                default:         err_next   = jvv_pkg::STATUS_SYNTAX;
                            endcase
                        end
                    end
                    jvv_pkg::ST_OPEN: begin
                    end
                    jvv_pkg::ST_KEY: begin
                        if (!is_ws) begin
                            if (head.cls == jvv_pkg::CL_QUOTE) begin
                                state_next = jvv_pkg::ST_KSTR;
                            end else begin
                                err_next = jvv_pkg::STATUS_SYNTAX;
                            end
                        end
                    end
                    jvv_pkg::ST_KSTR: begin
                        if (head.cls == jvv_pkg::CL_BSLASH) begin
                            state_next = jvv_pkg::ST_KESC;
                        end else if (head.cls == jvv_pkg::CL_QUOTE) begin
                            state_next = jvv_pkg::ST_COLON;
                        end
                    end
                    jvv_pkg::ST_KESC: state_next = jvv_pkg::ST_KSTR;
                    jvv_pkg::ST_COLON: begin
                        if (!is_ws) begin
                            if (head.cls == jvv_pkg::CL_COLON) begin
                                state_next = jvv_pkg::ST_VALUE;
                            end else begin
                                err_next = jvv_pkg::STATUS_SYNTAX;
                            end
                        end
                    end
                    jvv_pkg::ST_AFTER: begin
                        if (!is_ws) begin
                            if (head.cls == jvv_pkg::CL_COMMA) begin
                                state_next = top_obj ? jvv_pkg::ST_KEY : jvv_pkg::ST_VALUE;
                            end else if (closer_hit) begin
                                do_pop     = 1'b1;
                                end_at_inc = (level_reg == jvv_pkg::LVL_W'(1));
                                state_next = end_at_inc ? jvv_pkg::ST_TRAIL
                                                        : jvv_pkg::ST_AFTER;
                            end else begin
                                err_next = jvv_pkg::STATUS_SYNTAX;
                            end
                        end
                    end
                    jvv_pkg::ST_TRAIL: begin
                        if (!is_ws) begin
                            err_next = jvv_pkg::STATUS_SYNTAX;
                        end
                    end
                    jvv_pkg::ST_STR: begin
                        if (head.cls == jvv_pkg::CL_BSLASH) begin
                            state_next = jvv_pkg::ST_ESC;
                        end else if (head.cls == jvv_pkg::CL_QUOTE) begin
                            end_at_inc = (level_reg == '0);
                            state_next = end_at_inc ? jvv_pkg::ST_TRAIL : jvv_pkg::ST_AFTER;
                        end
                    end
                    jvv_pkg::ST_ESC: state_next = jvv_pkg::ST_STR;
                    jvv_pkg::ST_NUM: begin
                    end
                    jvv_pkg::ST_LIT: begin
                        if (lp_reg < jvv_pkg::LP_W'(jvv_pkg::LIT_COUNT) &&
                            head.data == jvv_pkg::lit_char(lp_reg)) begin
                            lp_inc = 1'b1;
                            if (jvv_pkg::lit_final(lp_reg)) begin
                                end_at_inc = (level_reg == '0);
                                state_next = end_at_inc ? jvv_pkg::ST_TRAIL
                                                        : jvv_pkg::ST_AFTER;
                            end
                        end else begin
                            err_next = jvv_pkg::STATUS_SYNTAX;
                        end
                    end
                    default: err_next = jvv_pkg::STATUS_SYNTAX;
                endcase
            end
        end
    end

    // marks, nesting level and the result of a finished text
    always_comb begin
        level_next = level_reg + jvv_pkg::LVL_W'(do_push) - jvv_pkg::LVL_W'(do_pop);
        start_next = set_start ? head.offset : start_reg;
        if (end_at_inc) begin
            end_next = off_inc;
        end else if (end_at_off) begin
            end_next = jvv_pkg::CNT_W'(head.offset);
        end else begin
            end_next = end_reg;
        end
        if (lp_load) begin
            lp_next = lp_load_val;
        end else if (lp_inc) begin
            lp_next = lp_reg + jvv_pkg::LP_W'(1);
        end else begin
            lp_next = lp_reg;
        end

        status    = err_next;
        end_final = end_next;
        if (err_next == jvv_pkg::STATUS_OK) begin
            if (state_next == jvv_pkg::ST_NUM && level_next == '0) begin
                end_final = off_inc;
            end else if (state_next != jvv_pkg::ST_TRAIL) begin
                status = jvv_pkg::STATUS_SYNTAX;
            end
        end
        res_next.status = status;
        if (status == jvv_pkg::STATUS_OK) begin
            res_next.value_start  = start_next;
            res_next.value_length = jvv_pkg::LEN_W'(end_final - jvv_pkg::CNT_W'(start_next));
        end else begin
            res_next.value_start  = '0;
            res_next.value_length = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && do_push) begin
            stack_reg[level_reg[jvv_pkg::IDX_W-1:0]] <= push_obj;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= jvv_pkg::ST_VALUE;
            level_reg <= '0;
            lp_reg    <= '0;
            start_reg <= '0;
            end_reg   <= '0;
            err_reg   <= jvv_pkg::STATUS_OK;
        end else if (pop) begin
            if (head.last) begin
                state_reg <= jvv_pkg::ST_VALUE;
                level_reg <= '0;
                lp_reg    <= '0;
                start_reg <= '0;
                end_reg   <= '0;
                err_reg   <= jvv_pkg::STATUS_OK;
            end else begin
                state_reg <= state_next;
                level_reg <= level_next;
                lp_reg    <= lp_next;
                start_reg <= start_next;
                end_reg   <= end_next;
                err_reg   <= err_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pop && head.last) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && head.last) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign result   = res_reg;

endmodule
`default_nettype wire

### src/json_value_validator.sv
// JSON value validator: top level joining front end, beat queue and scanner.
// Throughput: one byte per cycle if no result beat stalls; the scanner settles each byte in one step.
// Result path: the s_tlast beat is written into the queue, then the scanner reads it and the result
//   register captures the verdict and raises m_tvalid, when no earlier beats wait in the queue.
// Queue: 4 beats between front end and scanner; s_tready drops only when it is full.
// Reset: synchronous aresetn clears scanner state, queue and offset; the nesting stack is not cleared.
`default_nettype none
module json_value_validator (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [jvv_pkg::IN_DATA_W-1:0]   s_tdata,   // [7:0] data_byte
    input  wire logic                            s_tlast,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [jvv_pkg::OUT_DATA_W-1:0]       m_tdata    // [1:0] status, [17:2] value_start,
                                                            // [34:18] value_length, [39:35] 0
);

    jvv_pkg::beat_t             wr_beat;
    jvv_pkg::beat_t             rd_beat;
    jvv_pkg::result_t           out_res;
    logic                       push;
    logic                       pop;
    logic                       fifo_full;
    logic                       fifo_empty;
    logic [jvv_pkg::FIFO_AW:0]  fifo_fill;

    jvv_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .fifo_full (fifo_full),
        .push      (push),
        .beat      (wr_beat)
    );

    jvv_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wr_beat (wr_beat),
        .pop     (pop),
        .rd_beat (rd_beat),
        .full    (fifo_full),
        .empty   (fifo_empty),
        .fill    (fifo_fill)
    );

    jvv_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (rd_beat),
        .fifo_empty (fifo_empty),
        .pop        (pop),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .result     (out_res)
    );

    assign m_tdata = jvv_pkg::OUT_DATA_W'(out_res);

    a_err_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_res.status != jvv_pkg::STATUS_OK) |->
        (out_res.value_start == '0 && out_res.value_length == '0))
        else $error("error result carries nonzero fields");

    a_ok_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_res.status == jvv_pkg::STATUS_OK) |->
        (out_res.value_length != '0))
        else $error("valid result with empty value");

    a_fill_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (fifo_fill == $past(fifo_fill) + (jvv_pkg::FIFO_AW + 1)'(1)))
        else $error("queue fill did not count a write");

    a_fill_down: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !push) |=> (fifo_fill == $past(fifo_fill) - (jvv_pkg::FIFO_AW + 1)'(1)))
        else $error("queue fill did not count a read");

endmodule
`default_nettype wire

### bench/tb.sv
// Testbench for json_value_validator: byte-stream stimulus, scoreboard prediction, result checks.
`timescale 1ns / 1ps
module tb;
    import jvv_pkg::*;

    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int RANDOM_BYTES = 1420;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 16;

    localparam logic [8*13-1:0] LITERAL_CHARS = "truefalsenull";
    localparam logic [8*29-1:0] NUMBER_CHARS  = "0123456789.+-eExXabcdefABCDEF";
    localparam logic [8*13-1:0] JUNK_CHARS    = "{}[]\":,tfn0 \\";

    function automatic logic [7:0] literal_char(int unsigned i);
        return LITERAL_CHARS[8*(12-i) +: 8];
    endfunction

    class verdict_board;
        scan_state_t state;
        bit          is_object[MAX_NESTING];
        int unsigned level;
        int unsigned lit_pos;
        int unsigned offset;
        int unsigned start_mark;
        int unsigned end_mark;
        logic [1:0]  first_error;
        result_t     due[$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            state = ST_VALUE;
            foreach (is_object[i]) is_object[i] = 0;
            level       = 0;
            lit_pos     = 0;
            offset      = 0;
            start_mark  = 0;
            end_mark    = 0;
            first_error = STATUS_OK;
        endfunction

        function bit blank(logic [7:0] c);
            return c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A;
        endfunction

        function bit number_char(logic [7:0] c);
            return (c >= "0" && c <= "9") || c == "." || c == "+" || c == "-" ||
                   c == "e" || c == "E" || c == "x" || c == "X" ||
                   (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
        endfunction

        function void flag(logic [1:0] code);
            if (first_error == STATUS_OK) first_error = code;
        endfunction

        function bit top_object();
            if (level == 0 || level > MAX_NESTING) return 0;
            return is_object[level-1];
        endfunction

        function void finish_value(int unsigned stop);
            if (level == 0) begin
                end_mark = stop;
                state = ST_TRAIL;
            end else begin
                state = ST_AFTER;
            end
        endfunction

        // returns 1 when the byte has to be scanned again in the new state
        function bit scan_char(logic [7:0] c, int unsigned off);
            logic [7:0] closer;
            case (state)
                ST_VALUE: begin
                    if (blank(c)) return 0;
                    if (level == 0) start_mark = off;
                    if (c == "{" || c == "[") begin
                        if (level >= MAX_NESTING) begin
                            flag(STATUS_DEPTH);
                            return 0;
                        end
                        is_object[level] = (c == "{");
                        level++;
                        state = ST_OPEN;
                    end else if (c == "\"") begin
                        state = ST_STR;
                    end else if (c == "t") begin
                        lit_pos = 1;
                        state = ST_LIT;
                    end else if (c == "f") begin
                        lit_pos = 5;
                        state = ST_LIT;
                    end else if (c == "n") begin
                        lit_pos = 10;
                        state = ST_LIT;
                    end else if (number_char(c)) begin
                        state = ST_NUM;
                    end else begin
                        flag(STATUS_SYNTAX);
                    end
                    return 0;
                end
                ST_OPEN: begin
                    if (blank(c)) return 0;
                    closer = top_object() ? "}" : "]";
                    if (c == closer) begin
                        level--;
                        finish_value(off + 1);
                        return 0;
                    end
                    state = top_object() ? ST_KEY : ST_VALUE;
                    return 1;
                end
                ST_KEY: begin
                    if (blank(c)) return 0;
                    if (c == "\"") state = ST_KSTR;
                    else flag(STATUS_SYNTAX);
                    return 0;
                end
                ST_KSTR: begin
                    if (c == "\\") state = ST_KESC;
                    else if (c == "\"") state = ST_COLON;
                    return 0;
                end
                ST_KESC: begin
                    state = ST_KSTR;
                    return 0;
                end
                ST_COLON: begin
                    if (blank(c)) return 0;
                    if (c == ":") state = ST_VALUE;
                    else flag(STATUS_SYNTAX);
                    return 0;
                end
                ST_AFTER: begin
                    if (blank(c)) return 0;
                    closer = top_object() ? "}" : "]";
                    if (c == ",") begin
                        state = top_object() ? ST_KEY : ST_VALUE;
                    end else if (c == closer) begin
                        level--;
                        finish_value(off + 1);
                    end else begin
                        flag(STATUS_SYNTAX);
                    end
                    return 0;
                end
                ST_TRAIL: begin
                    if (!blank(c)) flag(STATUS_SYNTAX);
                    return 0;
                end
                ST_STR: begin
                    if (c == "\\") state = ST_ESC;
                    else if (c == "\"") finish_value(off + 1);
                    return 0;
                end
                ST_ESC: begin
                    state = ST_STR;
                    return 0;
                end
                ST_NUM: begin
                    if (number_char(c)) return 0;
                    finish_value(off);
                    return 1;
                end
                ST_LIT: begin
                    if (lit_pos < LIT_COUNT && c == literal_char(lit_pos)) begin
                        lit_pos++;
                        if (lit_pos == 4 || lit_pos == 9 || lit_pos == 13)
                            finish_value(off + 1);
                    end else begin
                        flag(STATUS_SYNTAX);
                    end
                    return 0;
                end
                default: begin
                    flag(STATUS_SYNTAX);
                    return 0;
                end
            endcase
        endfunction

        function void note_byte(logic [7:0] c, logic last);
            int unsigned off;
            int          guard;
            logic [1:0]  status;
            result_t     r;
            off = offset;
            if (off >= MAX_LENGTH) begin
                flag(STATUS_LENGTH);
            end else begin
                offset = off + 1;
                if (first_error == STATUS_OK) begin
                    guard = 0;
                    while (scan_char(c, off) && first_error == STATUS_OK && guard < 4)
                        guard++;
                end
            end
            if (!last) return;
            status = first_error;
            if (status == STATUS_OK) begin
                if (state == ST_NUM && level == 0) end_mark = offset;
                else if (state != ST_TRAIL) status = STATUS_SYNTAX;
            end
            r = '0;
            r.status = status;
            if (status == STATUS_OK) begin
                r.value_start  = start_mark[POS_W-1:0];
                r.value_length = LEN_W'(end_mark - start_mark);
            end
            due.push_back(r);
            restart();
        endfunction

        function void compare(string field, int unsigned want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] d);
            result_t want;
            if (due.size() == 0) begin
                $error("result beat with nothing outstanding: tdata=%h", d);
                mismatches++;
                return;
            end
            want = due.pop_front();
            compare("status", want.status, 32'(d[1:0]));
            compare("value_start", want.value_start, 32'(d[17:2]));
            compare("value_length", want.value_length, 32'(d[34:18]));
            compare("pad", 0, 32'(d[39:35]));
        endfunction

        function int pending();
            return due.size();
        endfunction
    endclass

    logic                  aclk     = 0;
    logic                  aresetn  = 0;
    logic                  s_tvalid = 0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  s_tlast  = 0;
    logic                  m_tvalid;
    logic                  m_tready = 0;
    logic [OUT_DATA_W-1:0] m_tdata;

    logic        calm     = 0;
    logic        hold_req = 0;
    int unsigned cycles   = 0;

    verdict_board board = new();

    logic [7:0] text_buf[$];
    bit         nest_obj[$];
    int         nest_left[$];
    int         nest_done[$];

    json_value_validator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) board.note_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) board.check_result(m_tdata);
        end
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(13, 60);
    endfunction

    initial begin : receiver
        int stall;
        bit held;
        stall = 0;
        held  = 0;
        forever begin
            @(posedge aclk);
            if (hold_req && !held) begin
                held  = 1;
                stall = HOLD_CYCLES;
            end else if (stall == 0 && !calm && $urandom_range(0, 3) == 0) begin
                stall = idle_len();
            end
            if (stall > 0) begin
                m_tready <= 0;
                stall--;
            end else begin
                m_tready <= 1;
            end
        end
    end

    task automatic send_byte(logic [7:0] b, logic last, bit quiet);
        int gap;
        gap = (!quiet && $urandom_range(0, 2) == 0) ? idle_len() : 0;
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_buffer(bit quiet);
        for (int i = 0; i < text_buf.size(); i++)
            send_byte(text_buf[i], i == text_buf.size() - 1, quiet);
    endtask

    task automatic send_str(string s);
        text_buf.delete();
        for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
        send_buffer(0);
    endtask

    function automatic void add_pad();
        if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(0, 3))
                    0:       text_buf.push_back(" ");
                    1:       text_buf.push_back(8'h09);
                    2:       text_buf.push_back(8'h0D);
                    default: text_buf.push_back(8'h0A);
                endcase
            end
        end
    endfunction

    function automatic void add_string();
        logic [7:0] b;
        text_buf.push_back("\"");
        repeat ($urandom_range(0, 6)) begin
            if ($urandom_range(0, 9) == 0) begin
                text_buf.push_back("\\");
                text_buf.push_back(8'($urandom_range(0, 255)));
            end else begin
                b = 8'($urandom_range(0, 255));
                if (b == "\"" || b == "\\") b = "a";
                text_buf.push_back(b);
            end
        end
        text_buf.push_back("\"");
    endfunction

    function automatic void add_scalar();
        int first;
        int len;
        int pick;
        case ($urandom_range(0, 3))
            0: add_string();
            1: begin
                pick  = $urandom_range(0, 2);
                first = (pick == 0) ? 0 : (pick == 1) ? 4 : 9;
                len   = (pick == 1) ? 5 : 4;
                for (int i = 0; i < len; i++) text_buf.push_back(literal_char(first + i));
            end
            default: begin
                // a value starting with 'f' is taken as the literal false
                do pick = $urandom_range(0, 28); while (pick == 22);
                text_buf.push_back(NUMBER_CHARS[8*(28-pick) +: 8]);
                repeat ($urandom_range(0, 4))
                    text_buf.push_back(NUMBER_CHARS[8*(28-$urandom_range(0, 28)) +: 8]);
            end
        endcase
    endfunction

    function automatic void add_value(int chain, int max_depth);
        int depth;
        depth = nest_obj.size();
        if (depth < chain || (depth < max_depth && $urandom_range(0, 99) < 35)) begin
            nest_obj.push_back(1'($urandom_range(0, 1)));
            text_buf.push_back(nest_obj[$] ? "{" : "[");
            nest_left.push_back(depth < chain ? 1 : $urandom_range(0, 3));
            nest_done.push_back(0);
        end else begin
            add_scalar();
        end
    endfunction

    function automatic void build_json(int chain, int max_depth);
        int t;
        add_pad();
        add_value(chain, max_depth);
        while (nest_obj.size() > 0) begin
            t = nest_obj.size() - 1;
            if (nest_done[t] == nest_left[t]) begin
                add_pad();
                text_buf.push_back(nest_obj[t] ? "}" : "]");
                void'(nest_obj.pop_back());
                void'(nest_left.pop_back());
                void'(nest_done.pop_back());
            end else begin
                if (nest_done[t] > 0) begin
                    add_pad();
                    text_buf.push_back(",");
                end
                nest_done[t]++;
                add_pad();
                if (nest_obj[t]) begin
                    add_string();
                    add_pad();
                    text_buf.push_back(":");
                    add_pad();
                end
                add_value(chain, max_depth);
            end
        end
        add_pad();
    endfunction

    initial begin : stimulus
        int  random_sent;
        int  kind;
        int  keep;
        bit  quiet;

        repeat (7) @(posedge aclk);
        aresetn <= 1;

        send_str(" \t\015\ntrue\n ");
        send_str("false");
        send_str("null");
        send_str("{}");
        send_str("[ ]");
        send_str("{\"a\":[1,-2.5e+3,0x1F,\"s\\\"q\"],\"b\\\\\":{\"c\":null}, \"d\" : false}");
        send_str("12345");
        send_str("  3.14  ");
        send_str(" ");
        send_str("\"abc");
        send_str("tru");
        send_str("{\"k\"");
        send_str("[1,2");
        send_str("[\"\\");
        send_str("flase");
        send_str("[1,]");
        send_str("{1:2}");
        send_str("{\"a\" 1}");
        send_str("true x");
        send_str("@");

        // nesting at the limit, one past it, and an earlier syntax error winning
        text_buf.delete();
        repeat (MAX_NESTING) text_buf.push_back("[");
        repeat (MAX_NESTING) text_buf.push_back("]");
        send_buffer(0);
        text_buf.delete();
        repeat (MAX_NESTING + 1) text_buf.push_back("[");
        send_buffer(0);
        text_buf.delete();
        text_buf.push_back("x");
        repeat (MAX_NESTING + 1) text_buf.push_back("[");
        send_buffer(0);

        text_buf = '{8'h00};
        send_buffer(0);
        text_buf = '{8'hFF};
        send_buffer(0);

        hold_req <= 1;
        random_sent = 0;
        while (random_sent < RANDOM_BYTES) begin
            text_buf.delete();
            kind  = $urandom_range(0, 99);
            quiet = ($urandom_range(0, 5) == 0);
            calm <= quiet;
            if (kind < 4) begin
                build_json($urandom_range(28, 36), 40);
            end else if (kind < 78) begin
                build_json(0, $urandom_range(0, 3));
            end else if (kind < 88) begin
                build_json(0, 3);
                text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(0, 255));
            end else if (kind < 95) begin
                build_json(0, 3);
                keep = (text_buf.size() > 1) ? $urandom_range(1, text_buf.size() - 1) : 1;
                while (text_buf.size() > keep) void'(text_buf.pop_back());
            end else begin
                repeat ($urandom_range(1, 12)) begin
                    if ($urandom_range(0, 1) == 0)
                        text_buf.push_back(8'($urandom_range(0, 255)));
                    else
                        text_buf.push_back(JUNK_CHARS[8*(12-$urandom_range(0, 12)) +: 8]);
                end
            end
            send_buffer(quiet);
            random_sent += text_buf.size();
        end

        s_tvalid <= 0;
        @(posedge aclk);
        while (board.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
